// ===== src/ce3_pkg.sv =====
package ce3_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH = 1024;
  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int ROW_LIMIT = 1024;
  localparam int YW        = 10;

  // Field and register widths.
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 24;
  localparam int DIM_W   = 11;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 14;
  localparam int COORD_W = 10;
  localparam int PROD_W  = 17;
  localparam int SUM_W   = 21;
  localparam int FRAC_W  = 6;

  // Request queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_MID     = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

  // Bit positions of the results one pixel can cause, in output order.
  localparam int RES_UP_LEFT  = 0;
  localparam int RES_UP_EDGE  = 1;
  localparam int RES_CUR_LEFT = 2;
  localparam int RES_CUR_EDGE = 3;
  localparam int NRES         = 4;

  typedef struct packed {
    logic [AW-1:0] wm1;
    logic [YW-1:0] hm1;
  } geom_t;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic [AW-1:0]         x;
    logic [YW-1:0]         y;
    logic [NRES-1:0]       mask;
  } entry_t;

endpackage

// ===== src/ce3_front.sv =====
module ce3_front import ce3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  geom_t            geom,
  input  logic             clear,
  input  logic [PIX_W-1:0] pixel,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  logic             q_full,
  output logic             push,
  output entry_t           push_entry
);

  logic [AW-1:0] col_count, x0;
  logic [YW-1:0] row_count, y0;
  logic          acc;

  logic [PIX_W-1:0] line_older [MAX_WIDTH];
  logic [PIX_W-1:0] line_newer [MAX_WIDTH];
  logic [PIX_W-1:0] rd_older, rd_newer;
  logic             fwd;
  logic [PIX_W-1:0] fwd_older, fwd_newer;

  logic             s1_valid, s1_row_end, s1_last_row;
  logic [PIX_W-1:0] s1_px;
  logic [AW-1:0]    s1_x;
  logic [YW-1:0]    s1_y;
  logic             s1_adv;
  logic [PIX_W-1:0] older_d, newer_d;
  logic [NRES-1:0]  mask;

  logic [8:0][PIX_W-1:0] win, win_next;

  // Position of the incoming pixel, held inside the frame.
  assign x0 = (col_count > geom.wm1) ? geom.wm1 : col_count;
  assign y0 = (row_count > geom.hm1) ? geom.hm1 : row_count;

  assign pixel_ready = !s1_valid || s1_adv;
  assign acc         = pixel_valid && pixel_ready;

  // Raster counters.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      if (x0 == geom.wm1) begin
        col_count <= '0;
        row_count <= (y0 == geom.hm1) ? '0 : y0 + 1'b1;
      end else begin
        col_count <= x0 + 1'b1;
        row_count <= y0;
      end
    end
  end

  // Line buffers: read on accept, written when the pixel leaves stage one.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_older <= line_older[x0];
      rd_newer <= line_newer[x0];
    end
    if (s1_adv) begin
      line_older[s1_x] <= newer_d;
      line_newer[s1_x] <= s1_px;
    end
  end

  // A write to the address being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (acc) begin
      fwd       <= s1_adv && (s1_x == x0);
      fwd_older <= newer_d;
      fwd_newer <= s1_px;
    end
  end

  assign older_d = fwd ? fwd_older : rd_older;
  assign newer_d = fwd ? fwd_newer : rd_newer;

  // Stage one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (acc) begin
      s1_px       <= pixel;
      s1_x        <= x0;
      s1_y        <= y0;
      s1_row_end  <= (x0 == geom.wm1);
      s1_last_row <= (y0 == geom.hm1);
    end
  end

  // Results this pixel causes.
  always_comb begin
    mask               = '0;
    mask[RES_UP_LEFT]  = (s1_y != '0) && (s1_x != '0);
    mask[RES_UP_EDGE]  = (s1_y != '0) && s1_row_end;
    mask[RES_CUR_LEFT] = s1_last_row && (s1_x != '0);
    mask[RES_CUR_EDGE] = s1_last_row && s1_row_end;
  end

  assign s1_adv = s1_valid && ((mask == '0) || !q_full);

  // Window shifts left by one column; the new column enters on the right.
  always_comb begin
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = older_d;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = newer_d;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_adv) begin
      win <= win_next;
    end
  end

  assign push            = s1_adv && (mask != '0);
  assign push_entry.win  = win_next;
  assign push_entry.x    = s1_x;
  assign push_entry.y    = s1_y;
  assign push_entry.mask = mask;

endmodule

// ===== src/ce3_queue.sv =====
module ce3_queue import ce3_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/ce3_back.sv =====
module ce3_back import ce3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [2:0][COEF_W-1:0] coef,
  input  entry_t                 head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [VAL_W-1:0]       filtered_value,
  output logic [COORD_W-1:0]     out_col,
  output logic [COORD_W-1:0]     out_row,
  output logic                   frame_done,
  output logic                   run_last
);

  logic            en, issue, last;
  logic [NRES-1:0] done, remaining, kbit;
  logic            edge_col, up_row;
  logic [1:0]      ci [3];
  logic [1:0]      ri [3];
  logic [AW-1:0]   ox;
  logic [YW-1:0]   oy;

  logic                            p_valid, p_fd, p_last;
  logic [8:0][PROD_W-1:0]          prod, prod_next;
  logic [AW-1:0]                   p_col;
  logic [YW-1:0]                   p_row;
  logic signed [SUM_W-1:0]         sum;

  assign en        = !result_valid || result_ready;
  assign remaining = head.mask & ~done;

  // Pick the first result still owed by the head request.
  always_comb begin
    kbit = '0;
    priority if (remaining[RES_UP_LEFT])  kbit[RES_UP_LEFT]  = 1'b1;
    else if (remaining[RES_UP_EDGE])      kbit[RES_UP_EDGE]  = 1'b1;
    else if (remaining[RES_CUR_LEFT])     kbit[RES_CUR_LEFT] = 1'b1;
    else                                  kbit[RES_CUR_EDGE] = 1'b1;
  end

  assign issue = !empty && en;
  assign last  = ((remaining & ~kbit) == '0);
  assign pop   = issue && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (pop) begin
      done <= '0;
    end else if (issue) begin
      done <= done | kbit;
    end
  end

  // Window columns and rows that the clamped neighborhood maps onto.
  assign edge_col = kbit[RES_UP_EDGE] || kbit[RES_CUR_EDGE];
  assign up_row   = kbit[RES_UP_LEFT] || kbit[RES_UP_EDGE];

  always_comb begin
    if (edge_col) begin
      ci[0] = (head.x != '0) ? 2'd1 : 2'd2;
      ci[1] = 2'd2;
      ci[2] = 2'd2;
    end else begin
      ci[0] = (head.x == AW'(1)) ? 2'd1 : 2'd0;
      ci[1] = 2'd1;
      ci[2] = 2'd2;
    end
    if (up_row) begin
      ri[0] = (head.y == YW'(1)) ? 2'd1 : 2'd0;
      ri[1] = 2'd1;
      ri[2] = 2'd2;
    end else begin
      ri[0] = (head.y != '0) ? 2'd1 : 2'd2;
      ri[1] = 2'd2;
      ri[2] = 2'd2;
    end
  end

  assign ox = edge_col ? head.x : head.x - 1'b1;
  assign oy = up_row ? head.y - 1'b1 : head.y;

  // Nine tap products.
  always_comb begin
    logic [3:0]       idx;
    logic [PIX_W-1:0] tap;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        idx = {2'b00, ri[i]} * 4'd3 + {2'b00, ci[j]};
        tap = coef[i][8*j +: 8];
        prod_next[3*i+j] = PROD_W'($signed({1'b0, head.win[idx]}) * $signed(tap));
      end
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= issue;
    end
    if (issue) begin
      prod   <= prod_next;
      p_col  <= ox;
      p_row  <= oy;
      p_fd   <= kbit[RES_CUR_EDGE];
      p_last <= last;
    end
  end

  // Sum of products; the output register floors it by the fraction shift.
  always_comb begin
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      sum = sum + SUM_W'($signed(prod[k]));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= p_valid;
    end
    if (en && p_valid) begin
      filtered_value <= VAL_W'(sum >>> FRAC_W);
      out_col        <= COORD_W'(p_col);
      out_row        <= COORD_W'(p_row);
      frame_done     <= p_fd;
      run_last       <= p_last;
    end
  end

endmodule

// ===== src/clamped_edge_convolution_3x3_top.sv =====
// A pixel's first result passes the stage one register, the request queue, the product
// stage and the output register. Throughput: one pixel per cycle while each pixel causes
// at most one result and result_ready holds; the back end issues one result per cycle, so
// pixels with several results (row ends, the last row) stall input once the queue is full.
// Reset (rst, synchronous, active high) restores the register defaults, empties the queue
// and clears counters and window; line buffer contents stay as they were.
module clamped_edge_convolution_3x3_top import ce3_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COEF_W-1:0]  cfg_data,
  input  logic [PIX_W-1:0]   pixel,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  output logic [VAL_W-1:0]   filtered_value,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  output logic               frame_done,
  output logic               run_last,
  output logic               result_valid,
  input  logic               result_ready
);

  logic [DIM_W-1:0]       image_width, image_height;
  logic [2:0][COEF_W-1:0] coef;
  geom_t                  geom;
  logic                   clear, push, pop, q_full, q_empty;
  entry_t                 push_entry, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(64);
      image_height <= DIM_W'(64);
      coef[0]      <= '0;
      coef[1]      <= COEF_W'(64);
      coef[2]      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_COEF_TOP:     coef[0]      <= cfg_data;
        REG_COEF_MID:     coef[1]      <= cfg_data;
        REG_COEF_BOTTOM:  coef[2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // A geometry write restarts the frame.
  assign clear = cfg_write &&
                 ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  // Effective last column and last row.
  always_comb begin
    if (image_width == '0) begin
      geom.wm1 = '0;
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      geom.wm1 = AW'(MAX_WIDTH - 1);
    end else begin
      geom.wm1 = AW'(image_width - 1'b1);
    end
    if (image_height == '0) begin
      geom.hm1 = '0;
    end else if (image_height > DIM_W'(ROW_LIMIT)) begin
      geom.hm1 = YW'(ROW_LIMIT - 1);
    end else begin
      geom.hm1 = YW'(image_height - 1'b1);
    end
  end

  ce3_front u_front (
    .clk, .rst, .geom, .clear, .pixel, .pixel_valid, .pixel_ready,
    .q_full, .push, .push_entry
  );

  ce3_queue u_queue (
    .clk, .rst, .push, .push_entry, .pop, .head, .full(q_full), .empty(q_empty)
  );

  ce3_back u_back (
    .clk, .rst, .coef, .head, .empty(q_empty), .pop, .result_valid, .result_ready,
    .filtered_value, .out_col, .out_row, .frame_done, .run_last
  );

endmodule

// ===== src/ce3_checker.sv =====
module ce3_checker import ce3_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pixel_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic [VAL_W-1:0]   filtered_value,
  input logic [COORD_W-1:0] out_col,
  input logic               frame_done,
  input logic               run_last
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value and column.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(filtered_value) && $stable(out_col))
    else $error("result payload changed while stalled");

  // The frame's final result is the last one of its pixel.
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_done |-> run_last)
    else $error("frame end without run end");

  // Reset leaves no result pending and the input open.
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && pixel_ready)
    else $error("state not cleared by reset");

endmodule

bind clamped_edge_convolution_3x3_top ce3_checker u_ce3_checker (
  .clk, .rst, .pixel_ready, .result_valid, .result_ready, .filtered_value,
  .out_col, .frame_done, .run_last
);
